### design/ddm_pkg.sv
package ddm_pkg;

	// field and register widths
	localparam int RANGE_BITS = 16;
	localparam int CFG_W      = 32;
	localparam int FRAC_BITS  = 32;

	// datapath widths of the squared shadow test
	localparam int P1_W  = RANGE_BITS + CFG_W;        // b * sin_res
	localparam int SQ_W  = 2 * RANGE_BITS;            // d * d, a * b
	localparam int ABO_W = SQ_W + CFG_W;              // a * b * one_minus_cos_res
	localparam int L_W   = 2 * P1_W;                  // (b * sin_res)^2
	localparam int X_W   = SQ_W + FRAC_BITS + 2;      // d^2 * 2^f + 2ab(1-cos)
	localparam int XH_W  = X_W - 2 * CFG_W;           // top slice of x
	localparam int ST2_W = 2 * CFG_W;                 // sin_thresh^2
	localparam int R_W   = ST2_W + X_W;               // full right-hand side
	localparam int TX_W  = CFG_W + XH_W;              // partial products with top slice
	localparam int M_W   = 2 * CFG_W + 1;             // partial sums
	localparam int RLO_W = 3 * CFG_W + 2;
	localparam int RHI_W = R_W - 2 * CFG_W;

	// config register reset values
	localparam logic [CFG_W-1:0] SIN_RES_RST    = 32'd18740250;
	localparam logic [CFG_W-1:0] OMC_RES_RST    = 32'd40891;
	localparam logic [CFG_W-1:0] SIN_THRESH_RST = 32'd224781300;

	// config register indexes
	localparam int REG_IDX_W = 2;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_SIN_RES    = 2'd0,
		REG_OMC_RES    = 2'd1,
		REG_SIN_THRESH = 2'd2
	} reg_idx_t;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// control that travels with each sample down the pipeline
	typedef struct packed {
		logic last;         // final sample of the scan
		logic pmask;        // prior mask of this sample
		logic pair_ok;      // this sample and the previous one form a testable pair
		logic prev_larger;  // previous sample is the farther one of the pair
	} ctl_t;

	typedef struct packed {
		logic mask;
		logic last_res;
	} res_t;

endpackage

### design/depth_discontinuity_mask.sv
// shadow point filter for one polar laser scan, one range word per cycle unless stalled
//
// input channel: range, range_infinite, prior_mask, last with in_valid / in_stall;
// a word is taken at a rising edge with in_valid high and in_stall low
// output channel: mask, last_res with out_valid / out_stall, same rule
// config: wr_en, wr_index, wr_data write sin_res, one_minus_cos_res and
// sin_thresh; write them only while no scan is in flight
//
// each new sample is paired with the one before it; the pair test runs down a
// nine-stage pipeline of 32x32 multiplies and wide adds, so one word is taken
// every cycle while the result queue has room. the mask of a sample enters
// the queue once the next sample has passed the pipeline. the last word of a
// scan pushes the mask of the sample before it, if there is one, and its own
// prior mask with last_res set. first and last samples keep their prior mask
//
// results wait in a four-word queue; the pipeline moves only while that queue
// has room for two words, so a stalled receiver backs up into in_stall and
// nothing is dropped or repeated
// reset clears the pipeline, the queue and the scan window and loads the
// default trig registers; no clearing pass is needed
module depth_discontinuity_mask
	import ddm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [RANGE_BITS-1:0] range,
	input  logic                  range_infinite,
	input  logic                  prior_mask,
	input  logic                  last,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  mask,
	output logic                  last_res,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [CFG_W-1:0]      wr_data
);

	// config registers
	logic [CFG_W-1:0] sin_res_q, omc_res_q, sin_thresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sin_res_q    <= SIN_RES_RST;
			omc_res_q    <= OMC_RES_RST;
			sin_thresh_q <= SIN_THRESH_RST;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_SIN_RES:    sin_res_q    <= wr_data;
				REG_OMC_RES:    omc_res_q    <= wr_data;
				REG_SIN_THRESH: sin_thresh_q <= wr_data;
				default: ;
			endcase
		end
	end

	// pipeline advance: the queue must have room for two words
	logic [CNT_W-1:0] cnt_q;
	logic             en;
	logic             accept;

	assign en       = (cnt_q <= CNT_W'(FIFO_DEPTH - 2));
	assign in_stall = !en;
	assign accept   = in_valid && en;

	// scan window at the input: the sample before the current one
	logic                  hhave_q;
	logic [RANGE_BITS-1:0] prev_range_q;
	logic                  prev_inf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hhave_q    <= 1'b0;
			prev_inf_q <= 1'b0;
		end else if (accept) begin
			hhave_q    <= !last;
			prev_inf_q <= range_infinite;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_range_q <= range;
		end
	end

	// pair setup: a is the farther sample, b the nearer one
	logic                  prev_larger;
	logic [RANGE_BITS-1:0] a_in, b_in;
	ctl_t                  ctl_in;

	always_comb begin
		prev_larger        = prev_range_q > range;
		a_in               = prev_larger ? prev_range_q : range;
		b_in               = prev_larger ? range : prev_range_q;
		ctl_in.last        = last;
		ctl_in.pmask       = prior_mask;
		ctl_in.pair_ok     = hhave_q && !prev_inf_q && !range_infinite &&
		                     (prev_range_q != range);
		ctl_in.prev_larger = prev_larger;
	end

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// datapath registers
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8, ctl_s9;

	// s1: pair
	logic [RANGE_BITS-1:0] a_s1, b_s1, d_s1;
	// s2: first products
	logic [P1_W-1:0]  p1_s2;
	logic [SQ_W-1:0]  d2_s2, ab_s2;
	logic [ST2_W-1:0] st2_s2;
	// s3: square of b*sin_res in pieces, ab*(1-cos)
	logic [SQ_W-1:0]         hh_s3;
	logic [P1_W-1:0]         hl_s3;
	logic [2*CFG_W-1:0]      ll_s3;
	logic [ABO_W-1:0]        abo_s3;
	logic [SQ_W-1:0]         d2_s3;
	logic [ST2_W-1:0]        st2_s3, st2_s4;
	// s4: left side and the bracket x
	logic [L_W-1:0] l_s4, l_s5, l_s6, l_s7, l_s8;
	logic [X_W-1:0] x_s4;
	// s5: partial products of sin_thresh^2 * x
	logic [2*CFG_W-1:0] t00_s5, t01_s5, t10_s5, t11_s5, t00_s6;
	logic [TX_W-1:0]    t02_s5, t12_s5, t12_s6;
	// s6, s7, s8: sum of the partial products
	logic [M_W-1:0]   m1_s6, m2_s6;
	logic [RLO_W-1:0] rlo_s7;
	logic [RHI_W-1:0] rhi_s7;
	logic [R_W-1:0]   r_s8;
	// s9: compare
	logic             hit_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
			ctl_s9 <= ctl_s8;

			a_s1 <= a_in;
			b_s1 <= b_in;
			d_s1 <= a_in - b_in;

			p1_s2  <= b_s1 * sin_res_q;
			d2_s2  <= d_s1 * d_s1;
			ab_s2  <= a_s1 * b_s1;
			st2_s2 <= sin_thresh_q * sin_thresh_q;

			// b*sin_res split at the config width: hi * 2^32 + lo
			hh_s3  <= p1_s2[P1_W-1:CFG_W] * p1_s2[P1_W-1:CFG_W];
			hl_s3  <= p1_s2[P1_W-1:CFG_W] * p1_s2[CFG_W-1:0];
			ll_s3  <= p1_s2[CFG_W-1:0] * p1_s2[CFG_W-1:0];
			abo_s3 <= ab_s2 * omc_res_q;
			d2_s3  <= d2_s2;
			st2_s3 <= st2_s2;

			l_s4   <= (L_W'(hh_s3) << (2 * CFG_W)) + (L_W'(hl_s3) << (CFG_W + 1)) +
			          L_W'(ll_s3);
			x_s4   <= (X_W'(d2_s3) << FRAC_BITS) + (X_W'(abo_s3) << 1);
			st2_s4 <= st2_s3;

			t00_s5 <= st2_s4[CFG_W-1:0] * x_s4[CFG_W-1:0];
			t01_s5 <= st2_s4[CFG_W-1:0] * x_s4[2*CFG_W-1:CFG_W];
			t10_s5 <= st2_s4[2*CFG_W-1:CFG_W] * x_s4[CFG_W-1:0];
			t11_s5 <= st2_s4[2*CFG_W-1:CFG_W] * x_s4[2*CFG_W-1:CFG_W];
			t02_s5 <= st2_s4[CFG_W-1:0] * x_s4[X_W-1:2*CFG_W];
			t12_s5 <= st2_s4[2*CFG_W-1:CFG_W] * x_s4[X_W-1:2*CFG_W];
			l_s5   <= l_s4;

			m1_s6  <= M_W'(t01_s5) + M_W'(t10_s5);
			m2_s6  <= M_W'(t11_s5) + M_W'(t02_s5);
			t00_s6 <= t00_s5;
			t12_s6 <= t12_s5;
			l_s6   <= l_s5;

			rlo_s7 <= RLO_W'(t00_s6) + (RLO_W'(m1_s6) << CFG_W);
			rhi_s7 <= RHI_W'(m2_s6) + (RHI_W'(t12_s6) << CFG_W);
			l_s7   <= l_s6;

			r_s8   <= R_W'(rlo_s7) + (R_W'(rhi_s7) << (2 * CFG_W));
			l_s8   <= l_s7;

			// shadowed when (b*sr)^2 * 2^f < st^2 * x
			hit_s9 <= (R_W'(l_s8) << FRAC_BITS) < r_s8;
		end
	end

	// scan window at the output: the sample whose mask is still open
	logic have_q, first_q, pmask_q, plhit_q;
	logic rhit, lhit, tail_go;
	res_t res_prev, res_cur, e0, e1;
	logic [1:0] push_n;

	always_comb begin
		// right neighbour shadows the held sample, or this sample's left one shadows it
		rhit              = ctl_s9.pair_ok && ctl_s9.prev_larger && hit_s9;
		lhit              = ctl_s9.pair_ok && !ctl_s9.prev_larger && hit_s9;
		tail_go           = en && v_s9;
		res_prev.mask     = pmask_q && !(!first_q && (plhit_q || rhit));
		res_prev.last_res = 1'b0;
		res_cur.mask      = ctl_s9.pmask;
		res_cur.last_res  = 1'b1;
		e0                = have_q ? res_prev : res_cur;
		e1                = res_cur;
		push_n            = tail_go ? ({1'b0, have_q} + {1'b0, ctl_s9.last}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			first_q <= 1'b1;
			pmask_q <= 1'b1;
			plhit_q <= 1'b0;
		end else if (tail_go) begin
			if (ctl_s9.last) begin
				have_q  <= 1'b0;
				first_q <= 1'b1;
			end else begin
				have_q  <= 1'b1;
				first_q <= !have_q;
				pmask_q <= ctl_s9.pmask;
				plhit_q <= lhit;
			end
		end
	end

	// result queue
	res_t             fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_nxt;
	logic             pop;

	assign wr_nxt    = wr_ptr_q + PTR_W'(1);
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign mask      = fifo_q[rd_ptr_q].mask;
	assign last_res  = fifo_q[rd_ptr_q].last_res;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= e0;
		end
		if (push_n == 2'd2) begin
			fifo_q[wr_nxt] <= e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

endmodule

### design/ddm_checker.sv
module ddm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic mask,
	input logic last_res
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mask) && $stable(last_res))
		else $error("output word changed under stall");

	// with nothing queued the input is never held off
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// input backpressure cannot clear while the receiver still stalls
	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && out_valid && out_stall |=> in_stall)
		else $error("input stall dropped without a word leaving");

	// reset empties the block
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("block not empty in reset");

endmodule

bind depth_discontinuity_mask ddm_checker u_ddm_checker (.*);

### sim/depth_discontinuity_mask_tb.sv
`timescale 1ns / 1ps

module depth_discontinuity_mask_tb;
	import ddm_pkg::*;

	// one ray of the scan as the driver presents it
	typedef struct {
		logic [RANGE_BITS-1:0] rng;
		logic                  inf;
		logic                  pmask;
		logic                  last_ray;
	} ray_t;

	localparam int DRAIN_CYCLES = 40;   // pipeline depth plus result queue, with margin

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [RANGE_BITS-1:0] range;
	logic                  range_infinite;
	logic                  prior_mask;
	logic                  last;
	logic                  out_valid;
	logic                  out_stall;
	logic                  mask;
	logic                  last_res;
	logic                  wr_en;
	reg_idx_t              wr_index;
	logic [CFG_W-1:0]      wr_data;

	depth_discontinuity_mask u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.range         (range),
		.range_infinite(range_infinite),
		.prior_mask    (prior_mask),
		.last          (last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.mask          (mask),
		.last_res      (last_res),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// rays waiting to be driven and mask words still owed by the block
	ray_t pending_rays[$];
	res_t owed_masks[$];

	// idle percentages for the sender and the receiver, changed per phase
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	// set at each rising edge when the presented ray was taken
	logic ray_taken;
	int   error_cnt;

	// trig registers as the block should hold them
	logic [CFG_W-1:0] trig_sin_res;
	logic [CFG_W-1:0] trig_omc_res;
	logic [CFG_W-1:0] trig_sin_thresh;

	// three-sample window of the scan
	logic [1:0]            win_held;
	logic [RANGE_BITS-1:0] win_mid_rng;
	logic [RANGE_BITS-1:0] win_left_rng;
	logic                  win_mid_inf;
	logic                  win_left_inf;
	logic                  win_mid_pmask;
	logic                  win_mid_first;

	function automatic void clear_window();
		win_held      = 2'd0;
		win_mid_rng   = '0;
		win_left_rng  = '0;
		win_mid_inf   = 1'b0;
		win_left_inf  = 1'b0;
		win_mid_pmask = 1'b1;
		win_mid_first = 1'b1;
	endfunction

	// squared shadow test on wide integers:
	// (b*sin_res)^2 * 2^f < sin_thresh^2 * ((a-b)^2 * 2^f + 2ab*omc)
	// 192 bits hold every product without wrap
	function automatic logic in_shadow(logic [RANGE_BITS-1:0] a, logic [RANGE_BITS-1:0] b);
		logic [191:0] wa, wb, ws, wo, wt, near_sq, far_sq, d2;
		wa = 192'(a);
		wb = 192'(b);
		ws = 192'(trig_sin_res);
		wo = 192'(trig_omc_res);
		wt = 192'(trig_sin_thresh);
		near_sq = wb * ws;
		near_sq = (near_sq * near_sq) << FRAC_BITS;
		d2 = wa - wb;
		d2 = (d2 * d2) << FRAC_BITS;
		far_sq = wa * wb * wo * 192'd2 + d2;
		far_sq = far_sq * (wt * wt);
		return near_sq < far_sq;
	endfunction

	// advance the scan window by one accepted ray and queue the masks it releases
	function automatic void shadow_mask_step(ray_t r);
		res_t  w;
		logic  hit;
		if (win_held != 2'd0) begin
			w.mask     = win_mid_pmask;
			w.last_res = 1'b0;
			// only a true interior sample with a finite range is tested
			if (!win_mid_first && win_held >= 2'd2 && !win_mid_inf) begin
				hit = 1'b0;
				if (!win_left_inf && win_mid_rng > win_left_rng
						&& in_shadow(win_mid_rng, win_left_rng))
					hit = 1'b1;
				if (!r.inf && win_mid_rng > r.rng && in_shadow(win_mid_rng, r.rng))
					hit = 1'b1;
				if (hit)
					w.mask = 1'b0;
			end
			owed_masks.push_back(w);
		end
		if (r.last_ray) begin
			// final ray keeps its prior mask and closes the scan
			w.mask     = r.pmask;
			w.last_res = 1'b1;
			owed_masks.push_back(w);
			clear_window();
		end else begin
			win_left_rng  = win_mid_rng;
			win_left_inf  = win_mid_inf;
			win_mid_rng   = r.rng;
			win_mid_inf   = r.inf;
			win_mid_pmask = r.pmask;
			win_mid_first = (win_held == 2'd0);
			if (win_held < 2'd2)
				win_held = win_held + 2'd1;
		end
	endfunction

	// driver: new word at the falling edge, held while stalled
	always @(negedge clk) begin : drive_rays
		ray_t r;
		if (in_valid && !ray_taken) begin
			// stalled word stays as it is
		end else if (pending_rays.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			r = pending_rays.pop_front();
			in_valid       <= 1'b1;
			range          <= r.rng;
			range_infinite <= r.inf;
			prior_mask     <= r.pmask;
			last           <= r.last_ray;
		end else begin
			in_valid <= 1'b0;
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// monitor: results checked first, then the accepted ray is predicted
	always @(posedge clk) begin : watch_ports
		res_t w;
		ray_t r;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_masks.size() == 0) begin
				$error("unexpected result word: mask %0b last_res %0b", mask, last_res);
				error_cnt++;
			end else begin
				w = owed_masks.pop_front();
				if (mask !== w.mask) begin
					$error("mask: expected %0b, actual %0b", w.mask, mask);
					error_cnt++;
				end
				if (last_res !== w.last_res) begin
					$error("last_res: expected %0b, actual %0b", w.last_res, last_res);
					error_cnt++;
				end
			end
		end
		ray_taken = arst_n && in_valid && !in_stall;
		if (ray_taken) begin
			r.rng      = range;
			r.inf      = range_infinite;
			r.pmask    = prior_mask;
			r.last_ray = last;
			shadow_mask_step(r);
		end
	end

	function automatic void push_ray(logic [RANGE_BITS-1:0] rng, logic inf, logic pmask,
			logic last_ray);
		ray_t r;
		r.rng      = rng;
		r.inf      = inf;
		r.pmask    = pmask;
		r.last_ray = last_ray;
		pending_rays.push_back(r);
	endfunction

	// wait until every word is driven and every mask has come back, then let the
	// pipeline settle
	task automatic wait_drained();
		while (pending_rays.size() != 0 || in_valid || owed_masks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write at a falling edge, only while the block is idle
	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		case (idx)
			REG_SIN_RES:    trig_sin_res    = val;
			REG_OMC_RES:    trig_omc_res    = val;
			REG_SIN_THRESH: trig_sin_thresh = val;
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// whole scans: mostly walls with small steps, some edges and jumps,
	// and some scans of pure noise
	task automatic queue_scans(int unsigned n_rays);
		int unsigned           queued;
		int unsigned           len;
		int unsigned           pick;
		logic                  noisy;
		logic [RANGE_BITS-1:0] cur;
		queued = 0;
		while (queued < n_rays) begin
			pick = $urandom_range(99);
			if (pick < 8)
				len = 1;
			else if (pick < 90)
				len = $urandom_range(16, 2);
			else
				len = $urandom_range(40, 17);
			noisy = ($urandom_range(9) == 0);
			cur = ($urandom_range(1) != 0) ? RANGE_BITS'($urandom)
				: RANGE_BITS'($urandom_range(300));
			for (int unsigned i = 0; i < len; i++) begin
				pick = $urandom_range(99);
				if (noisy || pick < 8)
					cur = RANGE_BITS'($urandom);
				else if (pick < 12)
					cur = '0;
				else if (pick < 35)
					cur = ($urandom_range(1) != 0) ? cur + RANGE_BITS'($urandom_range(512))
						: cur - RANGE_BITS'($urandom_range(512));
				else
					cur = ($urandom_range(1) != 0) ? cur + RANGE_BITS'($urandom_range(3))
						: cur - RANGE_BITS'($urandom_range(3));
				push_ray(cur,
					noisy ? 1'($urandom_range(1)) : ($urandom_range(99) < 8),
					$urandom_range(99) < 85,
					i == len - 1);
			end
			queued += len;
		end
	endtask

	task automatic run_phase(int unsigned snd_pct, int unsigned rcv_pct,
			int unsigned n_rays);
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		queue_scans(n_rays);
		wait_drained();
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		range          = '0;
		range_infinite = 1'b0;
		prior_mask     = 1'b0;
		last           = 1'b0;
		out_stall      = 1'b0;
		wr_en          = 1'b0;
		wr_index       = REG_SIN_RES;
		wr_data        = '0;
		ray_taken      = 1'b0;
		error_cnt      = 0;
		send_idle_pct  = 28;
		recv_idle_pct  = 86;
		trig_sin_res    = SIN_RES_RST;
		trig_omc_res    = OMC_RES_RST;
		trig_sin_thresh = SIN_THRESH_RST;
		clear_window();

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed scans on the reset trig values
		// single-ray scans, at the top and bottom of the range
		push_ray(16'hFFFF, 1'b0, 1'b1, 1'b1);
		push_ray(16'h0000, 1'b1, 1'b0, 1'b1);
		// two-ray scan: both are edge samples
		push_ray(16'd1000, 1'b0, 1'b1, 1'b0);
		push_ray(16'd200,  1'b0, 1'b0, 1'b1);
		// longer scan: equal neighbors, zero neighbor, max range, close walls,
		// infinite middle and infinite neighbor
		push_ray(16'd5000,  1'b0, 1'b1, 1'b0);
		push_ray(16'd5000,  1'b0, 1'b1, 1'b0);
		push_ray(16'd0,     1'b0, 1'b1, 1'b0);
		push_ray(16'hFFFF,  1'b0, 1'b1, 1'b0);
		push_ray(16'hFFFE,  1'b0, 1'b1, 1'b0);
		push_ray(16'd60000, 1'b0, 1'b0, 1'b0);
		push_ray(16'd30000, 1'b1, 1'b1, 1'b0);
		push_ray(16'd20000, 1'b0, 1'b1, 1'b0);
		push_ray(16'd19999, 1'b0, 1'b1, 1'b0);
		push_ray(16'd0,     1'b0, 1'b1, 1'b0);
		push_ray(16'd12000, 1'b0, 1'b0, 1'b0);
		push_ray(16'd11990, 1'b0, 1'b1, 1'b1);
		// tall infinite middle between a near first ray and the final ray
		push_ray(16'd300,   1'b0, 1'b1, 1'b0);
		push_ray(16'hFFFF,  1'b1, 1'b1, 1'b0);
		push_ray(16'd100,   1'b0, 1'b1, 1'b1);
		run_phase(28, 86, 150);

		// every register at its top value
		write_reg(REG_SIN_RES,    32'hFFFF_FFFF);
		write_reg(REG_OMC_RES,    32'hFFFF_FFFF);
		write_reg(REG_SIN_THRESH, 32'hFFFF_FFFF);
		run_phase(28, 86, 150);

		// zero threshold: nothing may be masked
		write_reg(REG_SIN_RES,    $urandom);
		write_reg(REG_OMC_RES,    $urandom);
		write_reg(REG_SIN_THRESH, 32'd0);
		run_phase(86, 28, 150);

		// zero resolution terms: any smaller finite neighbor masks
		write_reg(REG_SIN_RES,    32'd0);
		write_reg(REG_OMC_RES,    32'd0);
		write_reg(REG_SIN_THRESH, $urandom);
		run_phase(86, 28, 150);

		// values a real scanner would use
		write_reg(REG_SIN_RES,    $urandom_range(50_000_000, 1_000_000));
		write_reg(REG_OMC_RES,    $urandom_range(200_000, 1));
		write_reg(REG_SIN_THRESH, $urandom_range(32'h8000_0000, 32'h0100_0000));
		run_phase(0, 0, 150);

		// anything goes
		write_reg(REG_SIN_RES,    $urandom);
		write_reg(REG_OMC_RES,    $urandom);
		write_reg(REG_SIN_THRESH, $urandom);
		run_phase(0, 0, 150);

		if (error_cnt == 0)
			$display("depth_discontinuity_mask regression: pass");
		else
			$display("depth_discontinuity_mask regression: fail");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("depth_discontinuity_mask regression: fail");
		$finish;
	end

endmodule
